[rtl/osq_pkg.sv]
// Shared constants for the ordered sequence table: sizes, command codes, status codes.
// No dependencies; compiled first.
`default_nettype none

package osq_pkg;

    localparam int CAPACITY    = 256;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = ADDR_W + 1;

    // Field widths of the command and response beats
    localparam int FUNC_W   = 3;
    localparam int POS_W    = 8;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 8;
    localparam int COUNT_W  = 9;

    typedef logic [FUNC_W-1:0]   t_func;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_func F_INSERT_AT     = 3'd0;
    localparam t_func F_INSERT_SORTED = 3'd1;
    localparam t_func F_ERASE         = 3'd2;
    localparam t_func F_REMOVE_ALL    = 3'd3;
    localparam t_func F_GET           = 3'd4;
    localparam t_func F_SET           = 3'd5;
    localparam t_func F_FIND          = 3'd6;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_BAD_POS   = 2'd1;
    localparam t_status ST_FULL      = 2'd2;
    localparam t_status ST_NOT_FOUND = 2'd3;

endpackage

`default_nettype wire

[rtl/osq_cmd_if.sv]
// Command channel of the ordered sequence table: valid/ready plus the command fields.
// Depends on osq_pkg.
`default_nettype none

interface osq_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [osq_pkg::FUNC_W-1:0]  func;
    logic [osq_pkg::POS_W-1:0]   position;
    logic [osq_pkg::DATA_W-1:0]  data_value;

    modport source (output valid, output func, output position, output data_value,
                    input ready);
    modport sink   (input valid, input func, input position, input data_value,
                    output ready);
endinterface

`default_nettype wire

[rtl/osq_rsp_if.sv]
// Response channel of the ordered sequence table: valid/ready plus the result fields.
// Depends on osq_pkg.
`default_nettype none

interface osq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [osq_pkg::STATUS_W-1:0]  status;
    logic [osq_pkg::INDEX_W-1:0]   result_index;
    logic [osq_pkg::DATA_W-1:0]    read_value;
    logic [osq_pkg::COUNT_W-1:0]   removed_count;
    logic [osq_pkg::COUNT_W-1:0]   item_count;
    logic                          is_empty;

    modport source (output valid, output status, output result_index, output read_value,
                    output removed_count, output item_count, output is_empty,
                    input ready);
    modport sink   (input valid, input status, input result_index, input read_value,
                    input removed_count, input item_count, input is_empty,
                    output ready);
endinterface

`default_nettype wire

[rtl/ordered_sequence_table.sv]
// Ordered sequence table: fixed-capacity list held in one synchronous RAM plus a count.
// Depends on osq_pkg, osq_cmd_if and osq_rsp_if.
//
// Usage:
//   i_cmd carries one command beat (func, position, data_value); o_rsp returns exactly
//   one result beat per command, in order. One command is worked at a time; i_cmd.ready
//   is high only while the sequencer is idle. The result sits in an output register, so
//   the next command is taken while a finished result still waits on o_rsp.
//   All entry traffic goes through the single-port-read / single-port-write RAM
//   (one read and one write per cycle, read data registered), so commands that move
//   entries (insert_at, insert_sorted, erase, remove_all) or scan them (find) walk
//   the list one entry at a time; get, set and rejected commands do not.
//   Reset (i_rst_n low at a clock edge) empties the list; no clearing pass, entries are
//   only read below the count. If o_rsp stalls, the result holds and the block stops
//   before loading the following result until the output register frees.
`default_nettype none

module ordered_sequence_table (
    input  wire        i_clk,
    input  wire        i_rst_n,
    osq_cmd_if.sink    i_cmd,
    osq_rsp_if.source  o_rsp
);
    import osq_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_UP     = 3'd2;
    localparam logic [2:0] S_DOWN   = 3'd3;
    localparam logic [2:0] S_REMOVE = 3'd4;
    localparam logic [2:0] S_GET    = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

    logic [VALUE_WIDTH-1:0] mem_store [CAPACITY];

    logic [2:0]             r_state, n_state;
    t_func                  r_func, n_func;
    logic [ADDR_W-1:0]      r_pos, n_pos;
    logic [VALUE_WIDTH-1:0] r_val, n_val;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [CNT_W-1:0]       r_ptr, n_ptr;
    logic [CNT_W-1:0]       r_wptr, n_wptr;
    logic                   r_chk_vld, n_chk_vld;
    logic [ADDR_W-1:0]      r_chk_idx, n_chk_idx;
    logic [VALUE_WIDTH-1:0] r_rd_data;
    t_status                r_status, n_status;
    logic [ADDR_W-1:0]      r_index, n_index;
    logic [VALUE_WIDTH-1:0] r_rdval, n_rdval;
    logic [CNT_W-1:0]       r_removed, n_removed;
    logic                   r_ov, n_ov;

    t_status                r_o_status;
    logic [INDEX_W-1:0]     r_o_index;
    logic [DATA_W-1:0]      r_o_rdval;
    logic [COUNT_W-1:0]     r_o_removed;
    logic [COUNT_W-1:0]     r_o_count;

    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic                   cmd_fire;
    logic                   rsp_load;
    logic                   hit;
    logic [CNT_W-1:0]       pos_ext;
    logic [CNT_W-1:0]       cmd_pos_ext;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign cmd_fire    = i_cmd.valid && (r_state == S_IDLE);
    assign pos_ext     = {1'b0, r_pos};
    assign cmd_pos_ext = CNT_W'(i_cmd.position);

    // find looks for equality, sorted insert for the first entry not below the value
    assign hit = (r_func == F_FIND) ? (r_rd_data == r_val) : (r_rd_data >= r_val);

    always_comb begin
        n_state   = r_state;
        n_func    = r_func;
        n_pos     = r_pos;
        n_val     = r_val;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_wptr    = r_wptr;
        n_chk_vld = 1'b0;
        n_chk_idx = r_chk_idx;
        n_status  = r_status;
        n_index   = r_index;
        n_rdval   = r_rdval;
        n_removed = r_removed;
        n_ov      = r_ov && !o_rsp.ready;
        rd_en     = 1'b0;
        rd_addr   = r_ptr[ADDR_W-1:0];
        wr_en     = 1'b0;
        wr_addr   = r_chk_idx;
        wr_data   = r_rd_data;
        rsp_load  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (cmd_fire) begin
                    n_func    = i_cmd.func;
                    n_pos     = i_cmd.position[ADDR_W-1:0];
                    n_val     = i_cmd.data_value[VALUE_WIDTH-1:0];
                    n_status  = ST_OK;
                    n_index   = '0;
                    n_rdval   = '0;
                    n_removed = '0;
                    n_state   = S_FIN;
                    case (i_cmd.func)
                        F_INSERT_AT: begin
                            if (cmd_pos_ext > r_count) begin
                                n_status = ST_BAD_POS;
                            end else if (r_count >= FULL_COUNT) begin
                                n_status = ST_FULL;
                            end else begin
                                n_ptr   = r_count;
                                n_state = S_UP;
                            end
                        end
                        F_INSERT_SORTED: begin
                            if (r_count >= FULL_COUNT) begin
                                n_status = ST_FULL;
                            end else if (r_count == '0) begin
                                n_pos   = '0;
                                n_ptr   = '0;
                                n_state = S_UP;
                            end else begin
                                n_ptr   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        F_ERASE: begin
                            if (cmd_pos_ext >= r_count) begin
                                n_status = ST_BAD_POS;
                            end else begin
                                n_ptr   = cmd_pos_ext + CNT_W'(1);
                                n_state = S_DOWN;
                            end
                        end
                        F_REMOVE_ALL: begin
                            if (r_count != '0) begin
                                n_ptr   = '0;
                                n_wptr  = '0;
                                n_state = S_REMOVE;
                            end
                        end
                        F_GET: begin
                            if (cmd_pos_ext >= r_count) begin
                                n_status = ST_BAD_POS;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = i_cmd.position[ADDR_W-1:0];
                                n_state = S_GET;
                            end
                        end
                        F_SET: begin
                            if (cmd_pos_ext >= r_count) begin
                                n_status = ST_BAD_POS;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = i_cmd.position[ADDR_W-1:0];
                                wr_data = i_cmd.data_value[VALUE_WIDTH-1:0];
                            end
                        end
                        F_FIND: begin
                            if (r_count == '0) begin
                                n_status = ST_NOT_FOUND;
                            end else begin
                                n_ptr   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (r_chk_vld && hit) begin
                    // drop any read in flight and stop at the hit
                    if (r_func == F_FIND) begin
                        n_index = r_chk_idx;
                        n_state = S_FIN;
                    end else begin
                        n_pos   = r_chk_idx;
                        n_ptr   = r_count;
                        n_state = S_UP;
                    end
                end else if (r_ptr < r_count) begin
                    rd_en     = 1'b1;
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_ptr[ADDR_W-1:0];
                    n_ptr     = r_ptr + CNT_W'(1);
                end else if (r_chk_vld) begin
                    // last entry checked without a hit
                    if (r_func == F_FIND) begin
                        n_status = ST_NOT_FOUND;
                        n_state  = S_FIN;
                    end else begin
                        n_pos   = r_count[ADDR_W-1:0];
                        n_ptr   = r_count;
                        n_state = S_UP;
                    end
                end
            end

            S_UP: begin
                // entry r_ptr-1 moves to r_ptr; its write follows in the cycle after its read
                if (r_chk_vld) begin
                    wr_en = 1'b1;
                end
                if (r_ptr > pos_ext) begin
                    rd_en     = 1'b1;
                    rd_addr   = ADDR_W'(r_ptr - CNT_W'(1));
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_ptr[ADDR_W-1:0];
                    n_ptr     = r_ptr - CNT_W'(1);
                end else if (!r_chk_vld) begin
                    wr_en   = 1'b1;
                    wr_addr = r_pos;
                    wr_data = r_val;
                    n_count = r_count + CNT_W'(1);
                    n_index = r_pos;
                    n_state = S_FIN;
                end
            end

            S_DOWN: begin
                // entry r_ptr moves to r_ptr-1
                if (r_chk_vld) begin
                    wr_en = 1'b1;
                end
                if (r_ptr < r_count) begin
                    rd_en     = 1'b1;
                    n_chk_vld = 1'b1;
                    n_chk_idx = ADDR_W'(r_ptr - CNT_W'(1));
                    n_ptr     = r_ptr + CNT_W'(1);
                end else if (!r_chk_vld) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_FIN;
                end
            end

            S_REMOVE: begin
                // compact kept entries toward the front
                if (r_chk_vld && (r_rd_data != r_val)) begin
                    wr_en   = 1'b1;
                    wr_addr = r_wptr[ADDR_W-1:0];
                    n_wptr  = r_wptr + CNT_W'(1);
                end
                if (r_ptr < r_count) begin
                    rd_en     = 1'b1;
                    n_chk_vld = 1'b1;
                    n_ptr     = r_ptr + CNT_W'(1);
                end else if (!r_chk_vld) begin
                    n_removed = r_count - r_wptr;
                    n_count   = r_wptr;
                    n_state   = S_FIN;
                end
            end

            S_GET: begin
                n_rdval = r_rd_data;
                n_state = S_FIN;
            end

            S_FIN: begin
                if (!r_ov || o_rsp.ready) begin
                    rsp_load = 1'b1;
                    n_ov     = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_store[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem_store[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_chk_vld <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_chk_vld <= n_chk_vld;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_pos     <= n_pos;
        r_val     <= n_val;
        r_ptr     <= n_ptr;
        r_wptr    <= n_wptr;
        r_chk_idx <= n_chk_idx;
        r_status  <= n_status;
        r_index   <= n_index;
        r_rdval   <= n_rdval;
        r_removed <= n_removed;
        if (rsp_load) begin
            r_o_status  <= r_status;
            r_o_index   <= INDEX_W'(r_index);
            r_o_rdval   <= DATA_W'(r_rdval);
            r_o_removed <= COUNT_W'(r_removed);
            r_o_count   <= COUNT_W'(r_count);
        end
    end

    assign o_rsp.valid         = r_ov;
    assign o_rsp.status        = r_o_status;
    assign o_rsp.result_index  = r_o_index;
    assign o_rsp.read_value    = r_o_rdval;
    assign o_rsp.removed_count = r_o_removed;
    assign o_rsp.item_count    = r_o_count;
    assign o_rsp.is_empty      = (r_o_count == '0);

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("entry count above capacity");

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_chk_vld)
        else $error("RAM read still pending while idle");

    a_idle_count_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && !i_cmd.valid) |=> $stable(r_count))
        else $error("entry count moved without a command");

    a_compact_behind_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REMOVE) |-> ((r_wptr <= r_ptr) && (r_ptr <= r_count)))
        else $error("remove write pointer passed read pointer");

endmodule

`default_nettype wire
